[rtl/dsa_pkg.sv]
// Shared types and constants of the DFA string acceptor.
`default_nettype none
package dsa_pkg;

  localparam int NUM_STATES    = 16;
  localparam int STATE_BITS    = 4;
  localparam int SYMBOL_BITS   = 8;
  localparam int POSITION_BITS = 16;
  localparam int ADDR_BITS     = STATE_BITS + SYMBOL_BITS;
  localparam int TABLE_DEPTH   = NUM_STATES << SYMBOL_BITS;
  localparam int ENTRY_BITS    = STATE_BITS + 1;
  localparam int MASK_BITS     = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_CONSUME = 2'd2,
    OP_END     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ACK       = 3'd0,
    ST_STEPPED   = 3'd1,
    ST_STUCK     = 3'd2,
    ST_ACCEPT    = 3'd3,
    ST_NOT_FINAL = 3'd4,
    ST_NO_TRANS  = 3'd5,
    ST_NO_START  = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_STATE = 2'd0,
    REG_START_VALID = 2'd1,
    REG_FINAL_MASK  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    op_t                    op;
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   sym_ok;
    logic [STATE_BITS-1:0]  from_state;
    logic [STATE_BITS-1:0]  to_state;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic [STATE_BITS-1:0] start_state;
    logic                  start_valid;
    logic [MASK_BITS-1:0]  final_mask;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/dsa_ifs.sv]
// Valid/ready channel interfaces for input items and result beats.
`default_nettype none
interface dsa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] symbol;
  logic [3:0] from_state;
  logic [3:0] to_state;

  modport source (output valid, operation, symbol, from_state, to_state, input ready);
  modport sink   (input valid, operation, symbol, from_state, to_state, output ready);
endinterface

interface dsa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  current_state;
  logic [15:0] fail_position;

  modport source (output valid, status, current_state, fail_position, input ready);
  modport sink   (input valid, status, current_state, fail_position, output ready);
endinterface
`default_nettype wire

[rtl/dfa_string_acceptor_unit.sv]
// Top level of the table-driven DFA string acceptor.
//
//   channel   dir  payload                                      handshake
//   items     in   operation, symbol, from_state, to_state      valid/ready
//   results   out  status, current_state, fail_position         valid/ready
//   wr_*      in   wr_index, wr_data                            wr_en, no wait
//
// One item per cycle while results are accepted and no wipe or clear holds issue;
// each result beat passes the queue slot, registered table read and result register.
// A consume item's lookup address follows the run state left by the previous item.
// A wipe of all 4096 table entries runs after reset and after each clear item,
// during which no item beat is taken; register writes are taken at any time.
// Synchronous active-high reset; a stalled result beat holds and the queue fills.
`default_nettype none
module dfa_string_acceptor_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  dsa_in_if.sink                                   items,
  dsa_out_if.source                                results,
  input  wire logic                                wr_en,
  input  wire logic [dsa_pkg::CFG_IDX_BITS-1:0]    wr_index,
  input  wire logic [dsa_pkg::CFG_DATA_BITS-1:0]   wr_data
);
  import dsa_pkg::*;

  cfg_t    cfg;
  q_head_t head;
  logic    pop;
  logic    sweeping;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_START_STATE: cfg.start_state <= wr_data[STATE_BITS-1:0];
        REG_START_VALID: cfg.start_valid <= wr_data[0];
        REG_FINAL_MASK:  cfg.final_mask  <= wr_data[MASK_BITS-1:0];
        default:         cfg             <= cfg;
      endcase
    end
  end

  dsa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .sweeping (sweeping),
    .pop      (pop),
    .head     (head)
  );

  dsa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .cfg      (cfg),
    .pop      (pop),
    .sweeping (sweeping),
    .results  (results)
  );

endmodule
`default_nettype wire

[rtl/dsa_front.sv]
// Front end: accepts item beats, classifies them and queues them for the back end.
`default_nettype none
module dsa_front (
  input  wire logic       clk,
  input  wire logic       rst,
  dsa_in_if.sink          items,
  input  wire logic       sweeping,
  input  wire logic       pop,
  output dsa_pkg::q_head_t head
);
  import dsa_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      incoming;

  // no beats taken while the table is being wiped
  assign items.ready = (count != 2'd2) && !sweeping;
  assign push        = items.valid && items.ready;

  always_comb begin
    incoming.op         = op_t'(items.operation);
    incoming.symbol     = items.symbol;
    incoming.sym_ok     = (items.symbol != '0);
    incoming.from_state = items.from_state;
    incoming.to_state   = items.to_state;
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/dsa_back.sv]
// Back end: table lookup, run state update, table wipe and result register.
`default_nettype none
module dsa_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dsa_pkg::q_head_t head,
  input  wire dsa_pkg::cfg_t    cfg,
  output logic             pop,
  output logic             sweeping,
  dsa_out_if.source        results
);
  import dsa_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
  localparam logic [ADDR_BITS-1:0]     ADDR_MAX = ADDR_BITS'(TABLE_DEPTH - 1);

  logic [ENTRY_BITS-1:0] table_mem [TABLE_DEPTH];

  // run state
  logic [STATE_BITS-1:0]    present_state;
  logic                     dead_flag;
  logic [POSITION_BITS-1:0] symbol_counter;
  logic [POSITION_BITS-1:0] failed_at;

  // execute stage
  logic                  e2_valid;
  item_t                 e2_item;
  logic [ENTRY_BITS-1:0] rdata;
  logic                  fwd;
  logic [STATE_BITS-1:0] fwd_dest;

  logic [ADDR_BITS-1:0] sweep_cnt;

  logic e2_go;
  logic issue;
  logic blocked;

  logic                     entry_valid;
  logic [STATE_BITS-1:0]    entry_dest;
  logic                     have_start;
  logic [POSITION_BITS-1:0] cnt_inc;
  logic                     e2_writes;

  logic [STATE_BITS-1:0]    present_state_next;
  logic                     dead_flag_next;
  logic [POSITION_BITS-1:0] symbol_counter_next;
  logic [POSITION_BITS-1:0] failed_at_next;
  status_t                  res_status;
  logic [POSITION_BITS-1:0] res_fail;

  logic [STATE_BITS-1:0] live_state;
  logic [ADDR_BITS-1:0]  issue_addr;
  logic [ADDR_BITS-1:0]  load_addr;
  logic                  fwd_next;

  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [ENTRY_BITS-1:0] mem_wdata;

  assign e2_go   = e2_valid && (!results.valid || results.ready);
  // hold issue while a clear sits in execute or the wipe runs
  assign blocked = sweeping || (e2_valid && (e2_item.op == OP_CLEAR));
  assign issue   = head.valid && !blocked && (!e2_valid || e2_go);
  assign pop     = issue;

  assign entry_valid = fwd ? 1'b1 : rdata[ENTRY_BITS-1];
  assign entry_dest  = fwd ? fwd_dest : rdata[STATE_BITS-1:0];
  assign have_start  = cfg.start_valid && (32'(cfg.start_state) < NUM_STATES);
  assign cnt_inc     = (symbol_counter == POS_MAX) ? symbol_counter
                                                   : symbol_counter + 1'b1;
  assign load_addr   = {e2_item.from_state, e2_item.symbol};
  // first transition wins: write only into an empty entry
  assign e2_writes   = e2_valid && (e2_item.op == OP_LOAD) && e2_item.sym_ok
                       && !entry_valid;

  always_comb begin
    present_state_next  = present_state;
    dead_flag_next      = dead_flag;
    symbol_counter_next = symbol_counter;
    failed_at_next      = failed_at;
    res_status          = ST_ACK;
    res_fail            = failed_at;
    case (e2_item.op)
      OP_CONSUME: begin
        res_status = ST_STUCK;
        if (!have_start) begin
          symbol_counter_next = cnt_inc;
        end else if (!dead_flag) begin
          symbol_counter_next = cnt_inc;
          if (e2_item.sym_ok && entry_valid) begin
            present_state_next = entry_dest;
            res_status         = ST_STEPPED;
          end else begin
            dead_flag_next = 1'b1;
            failed_at_next = cnt_inc;
          end
        end
        res_fail = failed_at_next;
      end
      OP_END: begin
        if (!have_start) begin
          res_status = ST_NO_START;
        end else if (dead_flag) begin
          res_status = ST_NO_TRANS;
        end else if (cfg.final_mask[present_state]) begin
          res_status = ST_ACCEPT;
        end else begin
          res_status = ST_NOT_FINAL;
        end
        present_state_next  = have_start ? cfg.start_state : '0;
        dead_flag_next      = 1'b0;
        symbol_counter_next = '0;
        failed_at_next      = '0;
      end
      default: begin
        res_status = ST_ACK;
      end
    endcase
  end

  // state after the item in execute feeds the next lookup address
  assign live_state = e2_valid ? present_state_next : present_state;
  assign issue_addr = (head.item.op == OP_LOAD) ? {head.item.from_state, head.item.symbol}
                                                : {live_state, head.item.symbol};
  assign fwd_next   = e2_writes && (issue_addr == load_addr);

  assign mem_we    = sweeping || (e2_go && e2_writes);
  assign mem_waddr = sweeping ? sweep_cnt : load_addr;
  assign mem_wdata = sweeping ? '0 : {1'b1, e2_item.to_state};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= table_mem[issue_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      e2_item  <= head.item;
      fwd      <= fwd_next;
      fwd_dest <= e2_item.to_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_valid <= 1'b0;
    end else if (issue) begin
      e2_valid <= 1'b1;
    end else if (e2_go) begin
      e2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_state  <= '0;
      dead_flag      <= 1'b0;
      symbol_counter <= '0;
      failed_at      <= '0;
    end else if (e2_go) begin
      present_state  <= present_state_next;
      dead_flag      <= dead_flag_next;
      symbol_counter <= symbol_counter_next;
      failed_at      <= failed_at_next;
    end
  end

  // wipe the whole table after reset and after each clear
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping  <= 1'b1;
      sweep_cnt <= '0;
    end else if (sweeping) begin
      sweep_cnt <= sweep_cnt + 1'b1;
      if (sweep_cnt == ADDR_MAX) begin
        sweeping <= 1'b0;
      end
    end else if (e2_go && (e2_item.op == OP_CLEAR)) begin
      sweeping  <= 1'b1;
      sweep_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (e2_go) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e2_go) begin
      results.status        <= res_status;
      results.current_state <= present_state_next;
      results.fail_position <= res_fail;
    end
  end

endmodule
`default_nettype wire
